/* rtl/core/bitmap_id_allocator_defines.svh */
// Assertion macros for the bitmap ID allocator.
// Expects clk and arst_n in the scope of each use.
`ifndef BITMAP_ID_ALLOCATOR_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFINES_SVH

// Check a consequence in the same cycle.
`define BIA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the following cycle.
`define BIA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bia_pkg.sv */
// Shared types, constants and a helper function of the bitmap ID allocator.
// No dependencies.
`timescale 1ns / 1ps
package bia_pkg;

	localparam int WORD_BITS   = 32;
	localparam int MAX_WORDS   = 64;
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int WIDX_W      = $clog2(MAX_WORDS);
	localparam int WCNT_W      = 7;
	localparam int NUM_W       = 11;
	localparam int ST_W        = 2;
	localparam int WCNT_RESET  = 64;

	localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE    = 2'd1;
	localparam logic [ST_W-1:0] ST_NOSPACE  = 2'd2;
	localparam logic [ST_W-1:0] ST_NOTALLOC = 2'd3;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [NUM_W-1:0] lock_number;
	} req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [NUM_W-1:0] granted_number;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [WIDX_W-1:0] idx;
		logic              full;
	} sum_upd_t;

	typedef struct packed {
		logic              found;
		logic [WIDX_W-1:0] idx;
	} sum_hit_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] idx;
	} bit_hit_t;

	function automatic bit_hit_t first_zero(input logic [WORD_BITS-1:0] w);
		bit_hit_t r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r.found = 1'b1;
				r.idx   = BIT_W'(i);
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/bia_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/bia_summary.sv */
// Per-word written and full flags of the used-map, with the search for the
// lowest word in use that is not full. Depends on bia_pkg.
`timescale 1ns / 1ps
module bia_summary import bia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WIDX_W:0]   words,
	input  sum_upd_t          upd,
	input  logic [WIDX_W-1:0] rd_idx,
	output sum_hit_t          hit,
	output logic              rd_vld
);

	logic [MAX_WORDS-1:0] vld_q;
	logic [MAX_WORDS-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			full_q <= '0;
		end else if (upd.we) begin
			vld_q[upd.idx]  <= 1'b1;
			full_q[upd.idx] <= upd.full;
		end
	end

	always_comb begin
		hit = '0;
		for (int i = MAX_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i] && (32'(i) < 32'(words))) begin
				hit.found = 1'b1;
				hit.idx   = WIDX_W'(i);
			end
		end
	end

	assign rd_vld = vld_q[rd_idx];

endmodule

/* rtl/core/bitmap_id_allocator.sv */
// Bitmap ID allocator: lowest-free lock number allocation and release.
// Top level; depends on bia_pkg, bia_ram, bia_summary and the defines header.
//
// Use: a request transfer on in_valid/in_ready carries a kind (allocate or
// free) and a lock number. Each request gives exactly one response transfer
// on out_valid/out_ready with a status and the granted number.
// The configuration channel cfg_valid/cfg_ready writes the count of map
// words in use; cfg_ready is always high. Write it only while idle.
// Timing: one request is worked at a time. The lowest word that is not
// full is picked in the cycle of the request transfer. The request then
// passes S_READ, the map RAM read, and S_MOD, which modifies and writes
// back the word and registers the response. A new request is taken in
// the cycle after the write-back; the registered read data of the map
// RAM is why S_READ is needed.
// A stalled receiver holds the response in the output register; the next
// request is still taken, and its write-back waits until that register
// frees up.
// Reset: the word count returns to 64 and all written flags clear, so the
// whole map reads as free at once; no clearing pass is needed.
`timescale 1ns / 1ps
`include "bitmap_id_allocator_defines.svh"
module bitmap_id_allocator import bia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WCNT_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  req_t              in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsp_t              out_data
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_MOD} state_t;

	state_t            state_q;
	logic [WCNT_W-1:0] wcnt_q;
	logic              kind_q;
	logic              ok_q;
	logic [WIDX_W-1:0] widx_q;
	logic [BIT_W-1:0]  bit_q;
	logic              rvld_q;
	logic              out_valid_q;
	rsp_t              out_data_q;

	logic [WIDX_W:0]    words;
	logic               acc;
	logic               in_range;
	sum_hit_t           hit;
	logic               rd_vld;
	sum_upd_t           sum_upd;
	logic               ram_re;
	logic               ram_we;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] sel;
	bit_hit_t           fz;
	logic               do_wr;
	logic               mod_go;
	rsp_t               rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= WCNT_W'(WCNT_RESET);
		end else if (cfg_valid) begin
			wcnt_q <= cfg_data;
		end
	end

	assign words = (32'(wcnt_q) > MAX_WORDS) ? (WIDX_W + 1)'(MAX_WORDS)
	                                         : (WIDX_W + 1)'(wcnt_q);

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign in_range = 32'(in_data.lock_number[NUM_W-1:BIT_W]) < 32'(words);

	bia_summary u_summary (
		.clk    (clk),
		.arst_n (arst_n),
		.words  (words),
		.upd    (sum_upd),
		.rd_idx (widx_q),
		.hit    (hit),
		.rd_vld (rd_vld)
	);

	assign ram_re = (state_q == S_READ);

	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WORDS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (widx_q),
		.wdata (new_word),
		.re    (ram_re),
		.raddr (widx_q),
		.rdata (rdata)
	);

	always_comb begin
		word     = rvld_q ? rdata : '0;
		fz       = first_zero(word);
		sel      = '0;
		new_word = word;
		do_wr    = 1'b0;
		rsp      = '0;
		if (kind_q == KIND_ALLOC) begin
			sel = WORD_BITS'(1) << fz.idx;
			if (ok_q && fz.found) begin
				new_word = word | sel;
				do_wr    = 1'b1;
				rsp.status         = ST_OK;
				rsp.granted_number = NUM_W'({widx_q, fz.idx});
			end else begin
				rsp.status = ST_NOSPACE;
			end
		end else begin
			sel = WORD_BITS'(1) << bit_q;
			if (!ok_q) begin
				rsp.status = ST_RANGE;
			end else if ((word & sel) == '0) begin
				rsp.status = ST_NOTALLOC;
			end else begin
				new_word   = word & ~sel;
				do_wr      = 1'b1;
				rsp.status = ST_OK;
			end
		end
	end

	assign mod_go       = (state_q == S_MOD) && (!out_valid_q || out_ready);
	assign ram_we       = mod_go && do_wr;
	assign sum_upd.we   = ram_we;
	assign sum_upd.idx  = widx_q;
	assign sum_upd.full = (new_word == FULL_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !mod_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						kind_q <= in_data.kind;
						bit_q  <= in_data.lock_number[BIT_W-1:0];
						if (in_data.kind == KIND_ALLOC) begin
							widx_q <= hit.idx;
							ok_q   <= hit.found;
						end else begin
							widx_q <= WIDX_W'(in_data.lock_number[NUM_W-1:BIT_W]);
							ok_q   <= in_range;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					rvld_q  <= rd_vld;
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (mod_go) begin
						out_data_q  <= rsp;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`BIA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
		"request taken while another is in flight")
	`BIA_ASSERT_NOW(a_wr_rd_apart, ram_we, !ram_re,
		"map write overlaps a map read")
	`BIA_ASSERT_NOW(a_grant_zero, out_valid && (out_data.status != ST_OK),
		out_data.granted_number == '0, "failed request carries a number")

endmodule
